[hdl/mmie_pkg.sv]
// Shared constants, types and helpers for the mini-MIPS execute core.
package mmie_pkg;

  // Datapath sizing
  localparam int WORD_BITS  = 16;
  localparam int REG_COUNT  = 8;
  localparam int REG_BITS   = $clog2(REG_COUNT);
  localparam int DATA_DEPTH = 256;  // power of two, 16 to 256
  localparam int ADDR_BITS  = $clog2(DATA_DEPTH);
  localparam int PC_BITS    = 8;
  localparam int PORT_BITS  = 16;

  // Opcodes, instruction_word[15:12]
  localparam logic [3:0] OP_RTYPE = 4'd0;
  localparam logic [3:0] OP_J     = 4'd2;
  localparam logic [3:0] OP_ADDI  = 4'd4;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_LW    = 4'd11;
  localparam logic [3:0] OP_SW    = 4'd15;

  // R-type function codes, instruction_word[2:0]
  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  // Action codes
  localparam logic ACT_EXEC    = 1'b0;
  localparam logic ACT_PRELOAD = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [REG_BITS-1:0]  ridx_t;
  typedef logic [PC_BITS-1:0]   pc_t;

  // Outcome of one item, produced by the execute logic
  typedef struct packed {
    pc_t   npc;
    logic  taken;
    logic  rw;
    ridx_t ridx;
    word_t rval;
    logic  is_load;
    logic  mw;
    addr_t maddr;
    word_t mval;
  } exec_t;

  // Zero-extend or truncate a machine word to the 16-bit result ports
  function automatic logic [PORT_BITS-1:0] word_to_port(word_t w);
    logic [31:0] ext;
    ext = 32'(w);
    return ext[PORT_BITS-1:0];
  endfunction

  // Sign-extend or truncate a signed 16-bit port value to a machine word
  function automatic word_t port_to_word(logic signed [PORT_BITS-1:0] v);
    logic signed [31:0] ext;
    ext = 32'(v);
    return ext[WORD_BITS-1:0];
  endfunction

endpackage

[hdl/mmie_regfile.sv]
// Register file: one write port, two registered read ports with write-first bypass.
module mmie_regfile (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  mmie_pkg::ridx_t  waddr_i,
  input  mmie_pkg::word_t  wdata_i,
  input  logic             re_i,
  input  mmie_pkg::ridx_t  raddr_a_i,
  input  mmie_pkg::ridx_t  raddr_b_i,
  output mmie_pkg::word_t  rdata_a_o,
  output mmie_pkg::word_t  rdata_b_o
);
  import mmie_pkg::*;

  word_t                rf_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  word_t                rdata_a_q;
  word_t                rdata_b_q;
  word_t                rd_a;
  word_t                rd_b;

  // An entry never written reads as zero; a write in the same cycle wins
  always_comb begin
    rd_a = valid_q[raddr_a_i] ? rf_q[raddr_a_i] : '0;
    rd_b = valid_q[raddr_b_i] ? rf_q[raddr_b_i] : '0;
    if (we_i && (waddr_i == raddr_a_i)) rd_a = wdata_i;
    if (we_i && (waddr_i == raddr_b_i)) rd_b = wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rf_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= rd_a;
      rdata_b_q <= rd_b;
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[hdl/mmie_dmem.sv]
// Data memory: one write port, one registered read port, per-word written flags.
module mmie_dmem (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  mmie_pkg::addr_t  waddr_i,
  input  mmie_pkg::word_t  wdata_i,
  input  logic             re_i,
  input  mmie_pkg::addr_t  raddr_i,
  output mmie_pkg::word_t  rdata_o
);
  import mmie_pkg::*;

  word_t                 mem_q [DATA_DEPTH];
  logic [DATA_DEPTH-1:0] valid_q;
  word_t                 rdata_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // Unwritten words read as zero
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

[hdl/mmie_exec.sv]
// Instruction decode, ALU, address and next-pc logic for one item.
module mmie_exec (
  input  logic                  action_i,
  input  logic [15:0]           iw_i,
  input  logic [7:0]            load_address_i,
  input  logic signed [15:0]    load_value_i,
  input  mmie_pkg::word_t       a_i,
  input  mmie_pkg::word_t       b_i,
  input  mmie_pkg::pc_t         pc_i,
  output mmie_pkg::exec_t       res_o
);
  import mmie_pkg::*;

  logic [3:0] op;
  ridx_t      rt;
  ridx_t      rd;
  logic [2:0] fn;
  word_t      imm_w;
  word_t      sum;
  pc_t        imm_pc;
  pc_t        jmp_pc;

  assign op     = iw_i[15:12];
  assign rt     = iw_i[8:6];
  assign rd     = iw_i[5:3];
  assign fn     = iw_i[2:0];
  assign imm_w  = word_t'($signed(iw_i[5:0]));
  assign imm_pc = pc_t'($signed(iw_i[5:0]));
  assign jmp_pc = pc_t'($signed(iw_i[6:0]));
  assign sum    = a_i + imm_w;

  always_comb begin
    res_o         = '0;
    res_o.npc     = pc_i + pc_t'(1);
    if (action_i == ACT_PRELOAD) begin
      res_o.npc   = pc_i;
      res_o.mw    = 1'b1;
      res_o.maddr = load_address_i[ADDR_BITS-1:0];
      res_o.mval  = port_to_word(load_value_i);
    end else begin
      unique case (op)
        OP_RTYPE: begin
          res_o.ridx = rd;
          res_o.rw   = 1'b1;
          unique case (fn)
            FN_ADD:  res_o.rval = a_i + b_i;
            FN_SUB:  res_o.rval = a_i - b_i;
            FN_AND:  res_o.rval = a_i & b_i;
            FN_OR:   res_o.rval = a_i | b_i;
            default: begin
              res_o.rw   = 1'b0;
              res_o.ridx = '0;
            end
          endcase
        end
        OP_ADDI: begin
          res_o.rw   = 1'b1;
          res_o.ridx = rt;
          res_o.rval = sum;
        end
        OP_LW: begin
          // Loaded value joins in the next stage
          res_o.rw      = 1'b1;
          res_o.ridx    = rt;
          res_o.is_load = 1'b1;
          res_o.maddr   = sum[ADDR_BITS-1:0];
        end
        OP_SW: begin
          res_o.mw    = 1'b1;
          res_o.maddr = sum[ADDR_BITS-1:0];
          res_o.mval  = b_i;
        end
        OP_BEQ: begin
          if (a_i == b_i) begin
            res_o.taken = 1'b1;
            res_o.npc   = pc_i + pc_t'(1) + imm_pc;
          end
        end
        OP_J: begin
          res_o.taken = 1'b1;
          res_o.npc   = jmp_pc;
        end
        default: ;
      endcase
    end
  end

endmodule

[hdl/mini_mips_instruction_execute_core.sv]
// Top level of the mini-MIPS execute core: two-stage pipeline with forwarding.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | in_valid_i  | in_stall_o  | action, instruction_word, load_address/value
//  out     | out_valid_o | out_stall_i | next_pc, branch_taken, reg_*, mem_*
//
// One item per cycle unless stalled. An item passes the execute stage (input register
// plus registered register-file operands), then the result register. A load directly
// followed by an item naming the loaded register as rs or rt stalls that item while
// the load is in execute, as the loaded word comes from the data memory's read
// register. Reset clears registers, data memory flags and the pc at once; no sweep.
// A stalled output holds the result register and the execute stage behind it.
module mini_mips_instruction_execute_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [15:0]        instruction_word_i,
  input  logic [7:0]         load_address_i,
  input  logic signed [15:0] load_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         next_pc_o,
  output logic               branch_taken_o,
  output logic               reg_write_o,
  output logic [2:0]         reg_index_o,
  output logic signed [15:0] reg_value_o,
  output logic               mem_write_o,
  output logic [7:0]         mem_address_o,
  output logic signed [15:0] mem_value_o
);
  import mmie_pkg::*;

  // Execute stage
  logic               x_valid_q;
  logic               x_action_q;
  logic [15:0]        x_iw_q;
  logic [7:0]         x_laddr_q;
  logic signed [15:0] x_lval_q;
  logic               x_fwd_a_q;
  logic               x_fwd_b_q;
  word_t              x_fwd_val_q;
  exec_t              x_res;
  word_t              rf_a;
  word_t              rf_b;
  word_t              op_a;
  word_t              op_b;

  // Result stage
  logic               w_valid_q;
  logic               w_new_q;
  exec_t              w_res_q;
  word_t              ld_data;
  word_t              w_rval;
  word_t              w_mval;

  // Program counter
  pc_t                pc_q;

  logic               in_xfer;
  logic               out_xfer;
  logic               x_adv;
  logic               ld_hazard;
  ridx_t              in_rs;
  ridx_t              in_rt;
  logic               fwd_a;
  logic               fwd_b;

  assign in_rs = instruction_word_i[11:9];
  assign in_rt = instruction_word_i[8:6];

  // Advance execute into the result register when that register frees up
  assign x_adv    = x_valid_q && (!w_valid_q || !out_stall_i);
  assign out_xfer = w_valid_q && !out_stall_i;

  // Hold back an item that needs the target of a load still in execute
  assign ld_hazard = x_valid_q && x_res.is_load && (action_i == ACT_EXEC) &&
                     ((in_rs == x_res.ridx) || (in_rt == x_res.ridx));

  assign in_stall_o = x_valid_q && (!x_adv || ld_hazard);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Forward the execute-stage result to the incoming item's operands
  assign fwd_a = x_valid_q && x_res.rw && (x_res.ridx == in_rs);
  assign fwd_b = x_valid_q && x_res.rw && (x_res.ridx == in_rt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
      w_valid_q <= 1'b0;
      w_new_q   <= 1'b0;
      pc_q      <= '0;
    end else begin
      if (in_xfer) begin
        x_valid_q <= 1'b1;
      end else if (x_adv) begin
        x_valid_q <= 1'b0;
      end
      if (x_adv) begin
        w_valid_q <= 1'b1;
        pc_q      <= x_res.npc;
      end else if (out_xfer) begin
        w_valid_q <= 1'b0;
      end
      // Commit the register write in the first cycle of the result stage
      w_new_q <= x_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_action_q  <= action_i;
      x_iw_q      <= instruction_word_i;
      x_laddr_q   <= load_address_i;
      x_lval_q    <= load_value_i;
      x_fwd_a_q   <= fwd_a;
      x_fwd_b_q   <= fwd_b;
      x_fwd_val_q <= x_res.rval;
    end
    if (x_adv) begin
      w_res_q <= x_res;
    end
  end

  mmie_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (w_new_q && w_res_q.rw),
    .waddr_i   (w_res_q.ridx),
    .wdata_i   (w_rval),
    .re_i      (in_xfer),
    .raddr_a_i (in_rs),
    .raddr_b_i (in_rt),
    .rdata_a_o (rf_a),
    .rdata_b_o (rf_b)
  );

  assign op_a = x_fwd_a_q ? x_fwd_val_q : rf_a;
  assign op_b = x_fwd_b_q ? x_fwd_val_q : rf_b;

  mmie_exec u_exec (
    .action_i       (x_action_q),
    .iw_i           (x_iw_q),
    .load_address_i (x_laddr_q),
    .load_value_i   (x_lval_q),
    .a_i            (op_a),
    .b_i            (op_b),
    .pc_i           (pc_q),
    .res_o          (x_res)
  );

  // Stores and preloads write as they leave execute; the read port feeds loads
  mmie_dmem u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (x_adv && x_res.mw),
    .waddr_i (x_res.maddr),
    .wdata_i (x_res.mval),
    .re_i    (x_adv),
    .raddr_i (x_res.maddr),
    .rdata_o (ld_data)
  );

  assign w_rval = w_res_q.is_load ? ld_data : w_res_q.rval;
  assign w_mval = w_res_q.is_load ? ld_data : w_res_q.mval;

  assign out_valid_o    = w_valid_q;
  assign next_pc_o      = w_res_q.npc;
  assign branch_taken_o = w_res_q.taken;
  assign reg_write_o    = w_res_q.rw;
  assign reg_index_o    = w_res_q.ridx;
  assign reg_value_o    = $signed(word_to_port(w_rval));
  assign mem_write_o    = w_res_q.mw;
  assign mem_address_o  = 8'(w_res_q.maddr);
  assign mem_value_o    = $signed(word_to_port(w_mval));

endmodule
